@@ src/afr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the addressed frame receiver.
// No dependencies; used by afr_parser, addressed_frame_receiver_top and the testbench files.
package afr_pkg;

    localparam logic [6:0] BLOCK_PAYLOAD_LEN = 7'd69;
    localparam logic [6:0] LEN_CMD_N         = 7'd6;
    localparam logic [6:0] LEN_CMD_C         = 7'd7;
    localparam logic [6:0] LEN_CMD_ERVG      = 7'd3;

    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_V  = 8'h56;
    localparam logic [7:0] CH_G  = 8'h47;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [3:0] {
        ST_START1    = 4'd0,
        ST_START2    = 4'd1,
        ST_ADDR1     = 4'd2,
        ST_ADDR2     = 4'd3,
        ST_ADDR3     = 4'd4,
        ST_ADDR4     = 4'd5,
        ST_CMD1      = 4'd6,
        ST_CMD2      = 4'd7,
        ST_DATA      = 4'd8,
        ST_WAIT_CR   = 4'd9,
        ST_WAIT_LF_A = 4'd10,
        ST_WAIT_CR_B = 4'd11,
        ST_WAIT_LF   = 4'd12
    } t_state;

    typedef struct packed {
        logic       byte_present;
        logic [7:0] rx_byte;
        logic       framing_error;
        logic       overrun;
    } t_in_req;

    typedef struct packed {
        logic        frame_done;
        logic        data_valid;
        logic [6:0]  data_index;
        logic [7:0]  data_byte;
        logic [7:0]  command_first;
        logic [7:0]  command_second;
        logic [10:0] header_sum;
    } t_out_req;

    // parser context carried between requests
    typedef struct packed {
        t_state      state;
        logic [6:0]  payload_count;
        logic [6:0]  payload_total;
        logic [7:0]  first_cmd;
        logic [7:0]  second_cmd;
        logic [10:0] running_sum;
    } t_ctx;

endpackage

@@ src/afr_parser.sv @@
`timescale 1ns / 1ps
// Frame parser: next context and result for one polled request.
// Depends on afr_pkg.
module afr_parser
    import afr_pkg::*;
(
    input  t_ctx        i_ctx,
    input  t_in_req     i_req,
    input  logic [31:0] i_station_address,
    output t_ctx        o_ctx,
    output t_out_req    o_res
);

    logic       take;
    logic [7:0] c;
    logic [1:0] addr_k;
    logic [7:0] addr_byte;
    logic [6:0] count_inc;

    assign take      = i_req.byte_present && !i_req.framing_error && !i_req.overrun;
    assign c         = i_req.rx_byte;
    assign addr_k    = 2'(i_ctx.state - ST_ADDR1);
    assign addr_byte = i_station_address[8*addr_k +: 8];
    assign count_inc = i_ctx.payload_count + 7'd1;

    // next state and context
    always_comb begin
        o_ctx = i_ctx;
        if (take) begin
            unique case (i_ctx.state)
                ST_START1: begin
                    if (c == CH_S) o_ctx.state = ST_START2;
                end
                ST_START2: begin
                    o_ctx.state = (c == CH_T) ? ST_ADDR1 : ST_START1;
                end
                ST_ADDR1, ST_ADDR2, ST_ADDR3, ST_ADDR4: begin
                    if (i_ctx.state == ST_ADDR1) begin
                        o_ctx.running_sum = {3'd0, c};
                    end else begin
                        o_ctx.running_sum = i_ctx.running_sum + {3'd0, c};
                    end
                    o_ctx.state = (c == addr_byte) ? t_state'(i_ctx.state + 4'd1)
                                                   : ST_START1;
                end
                ST_CMD1: begin
                    o_ctx.running_sum = i_ctx.running_sum + {3'd0, c};
                    o_ctx.first_cmd   = c;
                    o_ctx.state       = ST_CMD2;
                end
                ST_CMD2: begin
                    o_ctx.running_sum = i_ctx.running_sum + {3'd0, c};
                    o_ctx.second_cmd  = c;
                    o_ctx.state       = ST_WAIT_CR;
                    if (i_ctx.first_cmd == CH_F) begin
                        if (c == CH_N) begin
                            o_ctx.payload_total = LEN_CMD_N;
                        end else if (c == CH_C) begin
                            o_ctx.payload_total = LEN_CMD_C;
                        end else if (c == CH_D) begin
                            o_ctx.payload_total = BLOCK_PAYLOAD_LEN;
                        end else if (c == CH_E || c == CH_R || c == CH_V || c == CH_G) begin
                            o_ctx.payload_total = LEN_CMD_ERVG;
                        end
                        if (c == CH_N || c == CH_C || c == CH_D || c == CH_E ||
                            c == CH_R || c == CH_V || c == CH_G) begin
                            o_ctx.payload_count = 7'd0;
                            o_ctx.state         = ST_DATA;
                        end
                    end
                end
                ST_DATA: begin
                    o_ctx.payload_count = count_inc;
                    if (count_inc >= i_ctx.payload_total) o_ctx.state = ST_WAIT_CR;
                end
                ST_WAIT_CR: begin
                    if (c == CH_CR) o_ctx.state = ST_WAIT_LF;
                end
                // the A/B terminator pair has no way in; kept as it behaves
                ST_WAIT_LF_A: begin
                    o_ctx.state = (c == CH_LF) ? ST_WAIT_CR_B : ST_WAIT_CR;
                end
                ST_WAIT_CR_B: begin
                    o_ctx.state = (c == CH_CR) ? ST_WAIT_LF : ST_WAIT_CR;
                end
                ST_WAIT_LF: begin
                    o_ctx.state = (c == CH_LF) ? ST_START1 : ST_WAIT_CR;
                end
                default: begin
                    o_ctx.state = ST_START1;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res                = '0;
        o_res.command_first  = o_ctx.first_cmd;
        o_res.command_second = o_ctx.second_cmd;
        o_res.header_sum     = o_ctx.running_sum;
        if (take) begin
            unique case (i_ctx.state)
                ST_DATA: begin
                    o_res.data_valid = 1'b1;
                    o_res.data_index = i_ctx.payload_count;
                    o_res.data_byte  = c;
                end
                ST_WAIT_LF: begin
                    o_res.frame_done = (c == CH_LF);
                end
                default: begin
                    o_res.frame_done = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ src/addressed_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// Addressed frame receiver: top level with request registers and context.
// Depends on afr_pkg and afr_parser.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_req) carries one receiver
//   poll per request. Output channel (o_out_valid / i_out_ready / o_out_req)
//   returns exactly one result per poll, in order.
//   i_cfg_wr_en / i_cfg_wr_data load the station address; write only while
//   no poll is in flight.
//   Path: an accepted poll waits in the input register; the parser logic
//   feeds the result register when that register is empty or being taken.
//   Throughput: one poll per cycle unless output stalls; context loads with result.
//   Stall: while i_out_ready is low the result register holds; the input
//   register still takes one more poll, then o_in_ready drops until the
//   result is taken.
//   Reset (i_rst_n low, synchronous): both registers empty, parser back to
//   hunting the start byte, commands, sum and station address cleared.
module addressed_frame_receiver_top
    import afr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_req    o_out_req
);

    logic [31:0] r_station_address;
    logic        r_in_valid;
    t_in_req     r_in_req;
    logic        r_out_valid;
    t_out_req    r_out_req;
    t_ctx        r_ctx;
    t_ctx        n_ctx;
    t_out_req    n_out_req;
    logic        advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    afr_parser u_parser (
        .i_ctx             (r_ctx),
        .i_req             (r_in_req),
        .i_station_address (r_station_address),
        .o_ctx             (n_ctx),
        .o_res             (n_out_req)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_address <= '0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_ctx             <= '{state: ST_START1, default: '0};
        end else begin
            if (i_cfg_wr_en) r_station_address <= i_cfg_wr_data;
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_req <= i_in_req;
        if (advance) r_out_req <= n_out_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

`ifndef SYNTHESIS
    a_done_xor_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_req.frame_done && o_out_req.data_valid))
        else $error("frame_done and data_valid both set");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.data_valid) |-> (o_out_req.data_index < BLOCK_PAYLOAD_LEN))
        else $error("payload index out of range");

    a_count_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx.state == ST_DATA) |-> (r_ctx.payload_count < r_ctx.payload_total))
        else $error("payload count reached total while collecting");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held poll lost");
`endif

endmodule

@@ tb/afr_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the addressed frame receiver: watches both channels and the
// address write port, predicts each poll's result and compares in order.
// Depends on afr_pkg.
module afr_result_checker
    import afr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_req     i_in_req,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_req    i_out_req,
    output int          o_outstanding,
    output int          o_error_count
);

    // predicted parser context
    logic [31:0] station_addr;
    t_state      parse_st;
    logic [6:0]  pay_count;
    logic [6:0]  pay_total;
    logic [7:0]  cmd_a;
    logic [7:0]  cmd_b;
    logic [10:0] header_acc;

    t_out_req    pending_results[$];
    int          errs = 0;

    function automatic t_out_req predict_poll(input t_in_req p);
        t_out_req   r;
        logic [7:0] c;
        logic [1:0] k;
        logic [6:0] len;
        r = '0;
        c = p.rx_byte;
        // overrun, framing error and an empty poll all leave the context alone
        if (!p.overrun && !p.framing_error && p.byte_present) begin
            case (parse_st)
                ST_START1: begin
                    if (c == CH_S) parse_st = ST_START2;
                end
                ST_START2: parse_st = (c == CH_T) ? ST_ADDR1 : ST_START1;
                ST_ADDR1, ST_ADDR2, ST_ADDR3, ST_ADDR4: begin
                    k = 2'(parse_st - ST_ADDR1);
                    // first address byte loads the sum; mismatching bytes still count
                    header_acc = (k == 2'd0) ? 11'(c) : header_acc + 11'(c);
                    parse_st = (c == station_addr[8*k +: 8]) ?
                               t_state'(parse_st + 4'd1) : ST_START1;
                end
                ST_CMD1: begin
                    header_acc = header_acc + 11'(c);
                    cmd_a      = c;
                    parse_st   = ST_CMD2;
                end
                ST_CMD2: begin
                    header_acc = header_acc + 11'(c);
                    cmd_b      = c;
                    parse_st   = ST_WAIT_CR;
                    len        = '0;
                    if (cmd_a == CH_F) begin
                        case (c)
                            CH_N:                   len = LEN_CMD_N;
                            CH_C:                   len = LEN_CMD_C;
                            CH_D:                   len = BLOCK_PAYLOAD_LEN;
                            CH_E, CH_R, CH_V, CH_G: len = LEN_CMD_ERVG;
                            default:                len = '0;
                        endcase
                    end
                    if (len != '0) begin
                        pay_count = '0;
                        pay_total = len;
                        parse_st  = ST_DATA;
                    end
                end
                ST_DATA: begin
                    r.data_valid = 1'b1;
                    r.data_index = pay_count;
                    r.data_byte  = c;
                    pay_count    = pay_count + 7'd1;
                    if (pay_count >= pay_total) parse_st = ST_WAIT_CR;
                end
                ST_WAIT_CR: begin
                    if (c == CH_CR) parse_st = ST_WAIT_LF;
                end
                ST_WAIT_LF_A: parse_st = (c == CH_LF) ? ST_WAIT_CR_B : ST_WAIT_CR;
                ST_WAIT_CR_B: parse_st = (c == CH_CR) ? ST_WAIT_LF : ST_WAIT_CR;
                ST_WAIT_LF: begin
                    if (c == CH_LF) begin
                        parse_st     = ST_START1;
                        r.frame_done = 1'b1;
                    end else begin
                        parse_st = ST_WAIT_CR;
                    end
                end
                default: parse_st = ST_START1;
            endcase
        end
        r.command_first  = cmd_a;
        r.command_second = cmd_b;
        r.header_sum     = header_acc;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errs++;
            if (errs <= 10)
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            station_addr = '0;
            parse_st     = ST_START1;
            pay_count    = '0;
            pay_total    = '0;
            cmd_a        = '0;
            cmd_b        = '0;
            header_acc   = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) station_addr = i_cfg_wr_data;
            // compare before queuing: a result never belongs to a same-edge request
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    errs++;
                    if (errs <= 10) $display("%0t: result with no request pending", $time);
                end else begin
                    want = pending_results.pop_front();
                    check_field("frame_done", 32'(want.frame_done),
                                32'(i_out_req.frame_done));
                    check_field("data_valid", 32'(want.data_valid),
                                32'(i_out_req.data_valid));
                    check_field("data_index", 32'(want.data_index),
                                32'(i_out_req.data_index));
                    check_field("data_byte", 32'(want.data_byte),
                                32'(i_out_req.data_byte));
                    check_field("command_first", 32'(want.command_first),
                                32'(i_out_req.command_first));
                    check_field("command_second", 32'(want.command_second),
                                32'(i_out_req.command_second));
                    check_field("header_sum", 32'(want.header_sum),
                                32'(i_out_req.header_sum));
                end
            end
            if (i_in_valid && i_in_ready) pending_results.push_back(predict_poll(i_in_req));
        end
        o_outstanding <= pending_results.size();
        o_error_count <= errs;
    end

endmodule

@@ tb/addressed_frame_receiver_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the addressed frame receiver: clock, reset, frame stimulus
// with random gaps and output stalls, and the final verdict.
// Depends on afr_pkg, addressed_frame_receiver_top and afr_result_checker.
module addressed_frame_receiver_top_tb;
    import afr_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic        i_out_ready   = 1'b0;
    t_in_req     i_in_req      = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_req    o_out_req;

    int          outstanding;
    int          error_count;
    int          polls_sent  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    logic        steady      = 1'b0;
    logic [31:0] station_cfg = '0;

    addressed_frame_receiver_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_req    (o_out_req)
    );

    afr_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_req    (o_out_req),
        .o_outstanding(outstanding),
        .o_error_count(error_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver side: mostly ready, short and occasional long stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (steady || $urandom_range(0, 99) < 70) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // bias toward the bytes the parser reacts to
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 19))
            0:       return CH_S;
            1:       return CH_T;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_req make_dropped();
        t_in_req r;
        r.byte_present  = 1'($urandom);
        r.rx_byte       = 8'($urandom);
        r.framing_error = 1'($urandom);
        r.overrun       = 1'($urandom);
        if (r.byte_present && !r.framing_error && !r.overrun) begin
            case ($urandom_range(0, 2))
                0:       r.overrun       = 1'b1;
                1:       r.framing_error = 1'b1;
                default: r.byte_present  = 1'b0;
            endcase
        end
        return r;
    endfunction

    // valid stays high across back-to-back requests; it drops only for a gap
    task automatic send_poll(input t_in_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        polls_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        send_poll(t_in_req'{byte_present: 1'b1, rx_byte: c, framing_error: 1'b0,
                            overrun: 1'b0});
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic load_station(input logic [31:0] addr);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        station_cfg = addr;
    endtask

    task automatic send_random_frame();
        logic [7:0] fb[$];
        logic [7:0] cmd2;
        int         kind;
        int         n;
        int         cut;
        int         term;
        kind = $urandom_range(0, 99);
        fb.push_back(CH_S);
        fb.push_back(CH_T);
        for (int k = 0; k < 4; k++) fb.push_back(station_cfg[8*k +: 8]);
        if (kind < 10) begin
            // line noise
            fb.delete();
            n = $urandom_range(1, 8);
            repeat (n) fb.push_back(pick_byte());
        end else if (kind < 22) begin
            // corrupt the start or one address byte and stop there
            cut = $urandom_range(1, 5);
            fb[cut] = fb[cut] ^ 8'($urandom_range(1, 255));
            while (fb.size() > cut + 1) fb.pop_back();
        end else begin
            n = 0;
            if (kind < 35) begin
                fb.push_back(pick_byte());
                fb.push_back(pick_byte());
            end else begin
                case ($urandom_range(0, 12))
                    0, 1:    begin cmd2 = CH_N; n = LEN_CMD_N; end
                    2, 3:    begin cmd2 = CH_C; n = LEN_CMD_C; end
                    4:       begin cmd2 = CH_D; n = BLOCK_PAYLOAD_LEN; end
                    5, 6:    begin cmd2 = CH_E; n = LEN_CMD_ERVG; end
                    7, 8:    begin cmd2 = CH_R; n = LEN_CMD_ERVG; end
                    9, 10:   begin cmd2 = CH_V; n = LEN_CMD_ERVG; end
                    default: begin cmd2 = CH_G; n = LEN_CMD_ERVG; end
                endcase
                fb.push_back(CH_F);
                fb.push_back(cmd2);
            end
            repeat (n) fb.push_back(pick_byte());
            repeat ($urandom_range(0, 2)) fb.push_back(pick_byte());
            term = $urandom_range(0, 9);
            if (term != 0) begin
                if (term == 1) begin
                    fb.push_back(CH_CR);
                    fb.push_back(8'h41);
                end
                fb.push_back(CH_CR);
                fb.push_back(CH_LF);
            end
        end
        foreach (fb[i]) begin
            if ($urandom_range(0, 99) < 8) send_poll(make_dropped());
            send_byte(fb[i]);
        end
    endtask

    initial begin
        logic [7:0]  directed_bytes[$];
        logic [31:0] phase_addr[4];
        int          phase_end[4];
        directed_bytes = {CH_S, CH_T, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CH_F, CH_E,
                          8'h00, 8'hFF, CH_CR,
                          CH_CR, 8'h78, CH_CR, CH_LF,
                          CH_S, CH_T, 8'hFF, 8'h00};
        phase_addr = '{32'h0000_0000, $urandom, 32'h0A0D_5453, $urandom};
        phase_end  = '{350, 650, 950, 1270};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_station(32'hFFFF_FFFF);
        // dropped polls: all flags, framing error alone, no byte
        send_poll(t_in_req'{byte_present: 1'b1, rx_byte: CH_S, framing_error: 1'b1,
                            overrun: 1'b1});
        send_poll(t_in_req'{byte_present: 1'b1, rx_byte: CH_S, framing_error: 1'b1,
                            overrun: 1'b0});
        send_poll(t_in_req'{byte_present: 1'b0, rx_byte: 8'hFF, framing_error: 1'b0,
                            overrun: 1'b0});
        // full frame, bad terminator, good terminator, then an address mismatch
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        for (int ph = 0; ph < 4; ph++) begin
            load_station(phase_addr[ph]);
            while (polls_sent < phase_end[ph]) begin
                steady <= ($urandom_range(0, 7) == 0);
                send_random_frame();
            end
        end

        wait_drained();
        steady <= 1'b0;
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
src/afr_pkg.sv
src/afr_parser.sv
src/addressed_frame_receiver_top.sv
tb/afr_result_checker.sv
tb/addressed_frame_receiver_top_tb.sv
